### rtl/core/tppm_pkg.sv
// Shared widths, register map codes and reset values for the three-phase presence monitor.
`timescale 1ns / 1ps
`default_nettype none

package tppm_pkg;

    // Field widths
    localparam int IN_W        = 17;   // tick counts
    localparam int ANGLE_W     = 9;
    localparam int TOL_W       = 8;
    localparam int CNT_W       = 5;    // debounce counters
    localparam int LOSS_W      = 2;
    localparam int MS_W        = 8;    // whole milliseconds, kept mod 256

    // Beat layout
    localparam int S_TDATA_W   = 56;   // 3 x 17 bits, padded to bytes
    localparam int M_TDATA_W   = 8;    // 5 flags, padded to a byte

    // APB
    localparam int APB_AW      = 4;
    localparam int APB_DW      = 32;
    localparam int REG_IDX_W   = 2;

    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_FAULT_ENABLE = 2'd0;
    localparam reg_idx_t REG_FIRST_ANGLE  = 2'd1;
    localparam reg_idx_t REG_SECOND_ANGLE = 2'd2;
    localparam reg_idx_t REG_TOLERANCE    = 2'd3;

    localparam logic [ANGLE_W-1:0] FIRST_ANGLE_RST  = 9'd120;
    localparam logic [ANGLE_W-1:0] SECOND_ANGLE_RST = 9'd240;
    localparam logic [TOL_W-1:0]   TOLERANCE_RST    = 8'd10;

    // Angle window math: 180*d against p*(A +/- T)
    localparam int ANG_SUM_W   = 11;   // signed, covers -255..766
    localparam int PROD_W      = 29;   // signed 18 x 11
    localparam int ANGLE_SCALE = 180;

    // Whole-ms rule bounds
    localparam logic [MS_W-1:0] MS_LATE_LO  = 8'd7;
    localparam logic [MS_W-1:0] MS_LATE_HI  = 8'd8;
    localparam logic [MS_W-1:0] MS_EARLY_LO = 8'd4;
    localparam logic [MS_W-1:0] MS_EARLY_HI = 8'd5;

    localparam logic [LOSS_W-1:0] LOSS_LIMIT = 2'd2;

    typedef logic signed [PROD_W-1:0] prod_t;

    // Per-phase verdicts of one window
    typedef struct packed {
        logic p_zero;
        logic good1;
        logic good2;
        logic good3;
    } verdict_t;

endpackage

`default_nettype wire

### rtl/core/three_phase_presence_monitor.sv
// Top level: three-phase presence monitor with APB register port and stream channels.
`timescale 1ns / 1ps
`default_nettype none

// A beat accepted into the input register passes the product stage, the verdict stage
//   and the flag/result register before it shows on m_tdata.
// Throughput: one beat per cycle; each stage holds its beat only while the next is full.
// The flag/counter update for one window is a step in the last stage.
// Reset (aresetn low, synchronous): pipeline empty, flags and counters zero,
//   registers back to fault_enable=0, angles 120/240, tolerance 10.
module three_phase_presence_monitor #(
    parameter int DEBOUNCE_LIMIT = 30,
    parameter int TICKS_PER_MS   = 800
) (
    input  wire                               aclk,
    input  wire                               aresetn,

    // APB register port
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [tppm_pkg::APB_AW-1:0]       paddr,
    input  wire  [tppm_pkg::APB_DW-1:0]       pwdata,
    output logic [tppm_pkg::APB_DW-1:0]       prdata,
    output logic                              pready,

    // Window beats
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // [16:0] period_ticks, [33:17] second_delay_ticks, [50:34] third_delay_ticks
    input  wire  [tppm_pkg::S_TDATA_W-1:0]    s_tdata,

    // Result beats
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // [0] power_present, [1] first_present, [2] second_present,
    // [3] third_present, [4] angle_fault
    output logic [tppm_pkg::M_TDATA_W-1:0]    m_tdata
);
    import tppm_pkg::*;

    // Floor division by TICKS_PER_MS through a reciprocal: exact for all 17-bit inputs
    // with the shift set to input width plus ceil(log2(divisor)).
    localparam int DIV_SHIFT            = IN_W + $clog2(TICKS_PER_MS);
    localparam int RECIP_W              = IN_W + 1;
    localparam int DIV_PROD_W           = IN_W + RECIP_W;
    localparam longint unsigned RECIP   =
        ((64'd1 << DIV_SHIFT) + longint'(TICKS_PER_MS) - 64'd1) / longint'(TICKS_PER_MS);
    localparam logic [CNT_W-1:0] DB_LIMIT = CNT_W'(DEBOUNCE_LIMIT);

    // ------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------
    logic                 fault_enable_reg;
    logic [ANGLE_W-1:0]   first_angle_reg;
    logic [ANGLE_W-1:0]   second_angle_reg;
    logic [TOL_W-1:0]     tolerance_reg;
    reg_idx_t             reg_idx;
    logic                 cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fault_enable_reg <= 1'b0;
            first_angle_reg  <= FIRST_ANGLE_RST;
            second_angle_reg <= SECOND_ANGLE_RST;
            tolerance_reg    <= TOLERANCE_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_FAULT_ENABLE: fault_enable_reg <= pwdata[0];
                REG_FIRST_ANGLE:  first_angle_reg  <= pwdata[ANGLE_W-1:0];
                REG_SECOND_ANGLE: second_angle_reg <= pwdata[ANGLE_W-1:0];
                REG_TOLERANCE:    tolerance_reg    <= pwdata[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FAULT_ENABLE: prdata = {{(APB_DW-1){1'b0}}, fault_enable_reg};
            REG_FIRST_ANGLE:  prdata = {{(APB_DW-ANGLE_W){1'b0}}, first_angle_reg};
            REG_SECOND_ANGLE: prdata = {{(APB_DW-ANGLE_W){1'b0}}, second_angle_reg};
            REG_TOLERANCE:    prdata = {{(APB_DW-TOL_W){1'b0}}, tolerance_reg};
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when empty or when it hands its
    // beat on, so bubbles close up while the result beat is stalled.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, m_valid_reg;
    logic free1, free2, free3, free_out;

    assign free_out = !m_valid_reg || m_tready;
    assign free3    = !s3_valid_reg || free_out;
    assign free2    = !s2_valid_reg || free3;
    assign free1    = !s1_valid_reg || free2;
    assign s_tready = free1;
    assign m_tvalid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (free1)    s1_valid_reg <= s_tvalid;
            if (free2)    s2_valid_reg <= s1_valid_reg;
            if (free3)    s3_valid_reg <= s2_valid_reg;
            if (free_out) m_valid_reg  <= s3_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic [IN_W-1:0] s1_p_reg, s1_d2_reg, s1_d3_reg;

    always_ff @(posedge aclk) begin
        if (free1) begin
            s1_p_reg  <= s_tdata[IN_W-1:0];
            s1_d2_reg <= s_tdata[2*IN_W-1:IN_W];
            s1_d3_reg <= s_tdata[3*IN_W-1:2*IN_W];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: products. Window bounds p*(A-T), p*(A+T) for both angles,
    // 180*d for both delays, whole-ms by reciprocal multiply.
    // ------------------------------------------------------------------
    logic signed [ANG_SUM_W-1:0] a1_lo, a1_hi, a2_lo, a2_hi;
    logic signed [IN_W:0]        p_s;
    prod_t lo1_next, hi1_next, lo2_next, hi2_next;
    prod_t lhs2_next, lhs3_next;
    logic [DIV_PROD_W-1:0] q2_prod, q3_prod, q2_sh, q3_sh;
    logic [MS_W-1:0]       m2_next, m3_next;

    prod_t lo1_reg, hi1_reg, lo2_reg, hi2_reg, lhs2_reg, lhs3_reg;
    logic [MS_W-1:0] m2_reg, m3_reg;
    logic            p_zero_reg;

    always_comb begin
        a1_lo = $signed({2'b00, first_angle_reg})  - $signed({3'b000, tolerance_reg});
        a1_hi = $signed({2'b00, first_angle_reg})  + $signed({3'b000, tolerance_reg});
        a2_lo = $signed({2'b00, second_angle_reg}) - $signed({3'b000, tolerance_reg});
        a2_hi = $signed({2'b00, second_angle_reg}) + $signed({3'b000, tolerance_reg});
        p_s   = $signed({1'b0, s1_p_reg});

        // operands sign-extended to the product width before the multiply
        lo1_next = PROD_W'(p_s) * PROD_W'(a1_lo);
        hi1_next = PROD_W'(p_s) * PROD_W'(a1_hi);
        lo2_next = PROD_W'(p_s) * PROD_W'(a2_lo);
        hi2_next = PROD_W'(p_s) * PROD_W'(a2_hi);

        // 180*d stays below 2^25, so the sign bit is always clear
        lhs2_next = $signed(PROD_W'(s1_d2_reg) * PROD_W'(ANGLE_SCALE));
        lhs3_next = $signed(PROD_W'(s1_d3_reg) * PROD_W'(ANGLE_SCALE));

        q2_prod = DIV_PROD_W'(s1_d2_reg) * DIV_PROD_W'(RECIP_W'(RECIP));
        q3_prod = DIV_PROD_W'(s1_d3_reg) * DIV_PROD_W'(RECIP_W'(RECIP));
        q2_sh   = q2_prod >> DIV_SHIFT;
        q3_sh   = q3_prod >> DIV_SHIFT;
        m2_next = q2_sh[MS_W-1:0];
        m3_next = q3_sh[MS_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (free2) begin
            lo1_reg    <= lo1_next;
            hi1_reg    <= hi1_next;
            lo2_reg    <= lo2_next;
            hi2_reg    <= hi2_next;
            lhs2_reg   <= lhs2_next;
            lhs3_reg   <= lhs3_next;
            m2_reg     <= m2_next;
            m3_reg     <= m3_next;
            p_zero_reg <= (s1_p_reg == '0);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: verdicts. Strict window compares, then the swap rule, then
    // the equal-ms rule (which wins over the swap).
    // ------------------------------------------------------------------
    verdict_t verdict_next, verdict_reg;
    logic     ok2, ok3, swap_hit;

    always_comb begin
        ok2 = (lhs2_reg > lo1_reg && lhs2_reg < hi1_reg) ||
              (lhs2_reg > lo2_reg && lhs2_reg < hi2_reg);
        ok3 = (lhs3_reg > lo1_reg && lhs3_reg < hi1_reg) ||
              (lhs3_reg > lo2_reg && lhs3_reg < hi2_reg);

        swap_hit = ((m2_reg inside {[MS_LATE_LO:MS_LATE_HI]}) &&
                    (m3_reg inside {[MS_EARLY_LO:MS_EARLY_HI]})) ||
                   ((m2_reg inside {[MS_EARLY_LO:MS_EARLY_HI]}) &&
                    (m3_reg inside {[MS_LATE_LO:MS_LATE_HI]}));

        verdict_next.p_zero = p_zero_reg;
        verdict_next.good1  = 1'b1;
        verdict_next.good2  = ok2;
        verdict_next.good3  = ok3;
        if (swap_hit) begin
            verdict_next.good1 = 1'b0;
            verdict_next.good2 = 1'b1;
            verdict_next.good3 = 1'b1;
        end
        if (m2_reg == m3_reg) begin
            verdict_next.good2 = 1'b0;
            verdict_next.good3 = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (free3) begin
            verdict_reg <= verdict_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: flag and counter update, done as the beat enters the result
    // register. The flags themselves are the result payload.
    // ------------------------------------------------------------------
    logic power_reg, first_reg, second_reg, third_reg, fault_reg;
    logic power_next, first_next, second_next, third_next, fault_next;
    logic [LOSS_W-1:0] loss_cnt_reg, loss_cnt_next;
    logic [CNT_W-1:0]  bad1_cnt_reg, bad2_cnt_reg, bad3_cnt_reg;
    logic [CNT_W-1:0]  bad1_cnt_next, bad2_cnt_next, bad3_cnt_next;
    logic [CNT_W-1:0]  fault_cnt_reg, clear_cnt_reg, fault_cnt_next, clear_cnt_next;
    logic [CNT_W-1:0]  cnt_tmp;
    logic              all_good;

    always_comb begin
        power_next     = power_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        third_next     = third_reg;
        fault_next     = fault_reg;
        loss_cnt_next  = loss_cnt_reg;
        bad1_cnt_next  = bad1_cnt_reg;
        bad2_cnt_next  = bad2_cnt_reg;
        bad3_cnt_next  = bad3_cnt_reg;
        fault_cnt_next = fault_cnt_reg;
        clear_cnt_next = clear_cnt_reg;
        cnt_tmp        = '0;
        all_good       = verdict_reg.good1 && verdict_reg.good2 && verdict_reg.good3;

        // power loss: third empty window in a row drops power and phase one
        if (verdict_reg.p_zero) begin
            if (loss_cnt_reg >= LOSS_LIMIT) begin
                power_next    = 1'b0;
                first_next    = 1'b0;
                loss_cnt_next = LOSS_W'(1);
            end else begin
                loss_cnt_next = loss_cnt_reg + LOSS_W'(1);
            end
        end else begin
            power_next    = 1'b1;
            first_next    = 1'b1;
            loss_cnt_next = '0;
        end

        // per-phase debounce
        if (verdict_reg.good1) begin
            first_next    = 1'b1;
            bad1_cnt_next = '0;
        end else if (bad1_cnt_reg >= DB_LIMIT) begin
            first_next    = 1'b0;
            bad1_cnt_next = CNT_W'(1);
        end else begin
            bad1_cnt_next = bad1_cnt_reg + CNT_W'(1);
        end

        if (verdict_reg.good2) begin
            second_next   = 1'b1;
            bad2_cnt_next = '0;
        end else if (bad2_cnt_reg >= DB_LIMIT) begin
            second_next   = 1'b0;
            bad2_cnt_next = CNT_W'(1);
        end else begin
            bad2_cnt_next = bad2_cnt_reg + CNT_W'(1);
        end

        if (verdict_reg.good3) begin
            third_next    = 1'b1;
            bad3_cnt_next = '0;
        end else if (bad3_cnt_reg >= DB_LIMIT) begin
            third_next    = 1'b0;
            bad3_cnt_next = CNT_W'(1);
        end else begin
            bad3_cnt_next = bad3_cnt_reg + CNT_W'(1);
        end

        // fault debounce; disabled means fault cleared, counters frozen
        if (fault_enable_reg) begin
            if (all_good) begin
                cnt_tmp        = clear_cnt_reg + CNT_W'(1);
                fault_cnt_next = '0;
                clear_cnt_next = cnt_tmp;
                if (cnt_tmp >= DB_LIMIT) begin
                    clear_cnt_next = '0;
                    fault_next     = 1'b0;
                end
            end else begin
                cnt_tmp        = fault_cnt_reg + CNT_W'(1);
                clear_cnt_next = '0;
                fault_cnt_next = cnt_tmp;
                if (cnt_tmp >= DB_LIMIT) begin
                    fault_cnt_next = '0;
                    fault_next     = 1'b1;
                end
            end
        end else begin
            fault_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            power_reg     <= 1'b0;
            first_reg     <= 1'b0;
            second_reg    <= 1'b0;
            third_reg     <= 1'b0;
            fault_reg     <= 1'b0;
            loss_cnt_reg  <= '0;
            bad1_cnt_reg  <= '0;
            bad2_cnt_reg  <= '0;
            bad3_cnt_reg  <= '0;
            fault_cnt_reg <= '0;
            clear_cnt_reg <= '0;
        end else if (free_out && s3_valid_reg) begin
            power_reg     <= power_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            third_reg     <= third_next;
            fault_reg     <= fault_next;
            loss_cnt_reg  <= loss_cnt_next;
            bad1_cnt_reg  <= bad1_cnt_next;
            bad2_cnt_reg  <= bad2_cnt_next;
            bad3_cnt_reg  <= bad3_cnt_next;
            fault_cnt_reg <= fault_cnt_next;
            clear_cnt_reg <= clear_cnt_next;
        end
    end

    assign m_tdata = {{(M_TDATA_W-5){1'b0}},
                      fault_reg, third_reg, second_reg, first_reg, power_reg};

endmodule

`default_nettype wire

### rtl/core/tppm_checker.sv
// Port-level checker for the three-phase presence monitor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tppm_checker (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            pready,
    input  wire                            s_tready,
    input  wire                            m_tvalid,
    input  wire                            m_tready,
    input  wire [tppm_pkg::M_TDATA_W-1:0]  m_tdata
);
    import tppm_pkg::*;

    // a stalled result beat stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed while stalled");

    // with no result pending the whole pipeline can move, so input is open
    a_open: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // pad bits above the five flags stay zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:5] == '0))
        else $error("nonzero pad bits in result beat");

    // register port never inserts wait states
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind three_phase_presence_monitor tppm_checker u_tppm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .pready   (pready),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

### sim/tb.sv
// Self-checking testbench for the three-phase presence monitor: predicted flags vs result beats.
`timescale 1ns / 1ps

module tb;
    import tppm_pkg::*;

    localparam int DEBOUNCE_LIMIT = 30;
    localparam int TICKS_PER_MS   = 800;
    localparam int IN_MAX         = (1 << IN_W) - 1;
    localparam int MAX_REPORTS    = 10;
    // Four-stage pipeline; let it drain before touching registers or ending.
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int CYCLE_LIMIT    = 200000;

    // Window beat, period in the low bits of s_tdata.
    typedef struct packed {
        logic [IN_W-1:0] third_delay;
        logic [IN_W-1:0] second_delay;
        logic [IN_W-1:0] period;
    } window_t;

    // Result beat, power_present in bit 0.
    typedef struct packed {
        logic angle_fault;
        logic third_present;
        logic second_present;
        logic first_present;
        logic power_present;
    } flags_t;

    // Shapes of window the random stimulus is built from.
    typedef enum {
        WIN_GOOD,        // both delays near the configured lags
        WIN_SECOND_BAD,  // phase-two delay anywhere
        WIN_THIRD_BAD,   // phase-three delay anywhere
        WIN_SWAPPED,     // 7..8 ms against 4..5 ms, phase one bad
        WIN_SAME_MS,     // both delays in the same whole millisecond
        WIN_NO_EDGE,     // zero period, power-loss path
        WIN_NOISE        // every field fully random
    } window_kind_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [APB_AW-1:0]    paddr    = '0;
    logic [APB_DW-1:0]    pwdata   = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    three_phase_presence_monitor #(
        .DEBOUNCE_LIMIT (DEBOUNCE_LIMIT),
        .TICKS_PER_MS   (TICKS_PER_MS)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the monitor: register copies and flag/counter state.
    // ------------------------------------------------------------------
    logic               fault_en_cfg     = 1'b0;
    logic [ANGLE_W-1:0] first_angle_cfg  = FIRST_ANGLE_RST;
    logic [ANGLE_W-1:0] second_angle_cfg = SECOND_ANGLE_RST;
    logic [TOL_W-1:0]   tol_cfg          = TOLERANCE_RST;

    logic               power_q = 1'b0;
    logic               first_q = 1'b0;
    logic               second_q = 1'b0;
    logic               third_q = 1'b0;
    logic               fault_q = 1'b0;
    logic [LOSS_W-1:0]  loss_cnt = '0;
    logic [CNT_W-1:0]   first_bad_cnt = '0;
    logic [CNT_W-1:0]   second_bad_cnt = '0;
    logic [CNT_W-1:0]   third_bad_cnt = '0;
    logic [CNT_W-1:0]   fault_cnt = '0;
    logic [CNT_W-1:0]   clear_cnt = '0;

    flags_t pending_flags[$];   // expected result beats, oldest first

    // Run bookkeeping
    int  cycle_count   = 0;
    int  mismatches    = 0;
    int  windows_sent  = 0;
    int  results_seen  = 0;
    int  fault_results = 0;
    int  reg_writes    = 0;
    int  hold_left     = 0;     // receiver hold-off, counted down below
    logic src_idle_en  = 1'b1;
    logic sink_idle_en = 1'b1;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Long receiver hold-off, armed by the back-pressure test.
    always @(posedge aclk) begin
        if (hold_left > 0) hold_left <= hold_left - 1;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Strict test 180*d inside p*(A-T)..p*(A+T) for either configured lag.
    // Signed 64-bit, so A-T may go negative.
    function automatic logic lag_ok(input logic [IN_W-1:0] period,
                                    input logic [IN_W-1:0] lag);
        longint p, scaled, t, a1, a2;
        p      = period;
        t      = tol_cfg;
        a1     = first_angle_cfg;
        a2     = second_angle_cfg;
        scaled = ANGLE_SCALE * longint'(lag);
        return (scaled > p * (a1 - t) && scaled < p * (a1 + t)) ||
               (scaled > p * (a2 - t) && scaled < p * (a2 + t));
    endfunction

    // Bad window: clear after the limit, then count. Good window: set and zero.
    task automatic debounce_phase(input logic good, inout logic flag,
                                  inout logic [CNT_W-1:0] cnt);
        if (!good) begin
            if (cnt >= DEBOUNCE_LIMIT) begin
                flag = 1'b0;
                cnt  = '0;
            end
            cnt = cnt + 1'b1;
        end else begin
            flag = 1'b1;
            cnt  = '0;
        end
    endtask

    task automatic predict_window(input window_t w, output flags_t f);
        logic            good1, good2, good3;
        logic [MS_W-1:0] ms2, ms3;
        good1 = 1'b1;
        good2 = lag_ok(w.period, w.second_delay);
        good3 = lag_ok(w.period, w.third_delay);
        ms2   = MS_W'(w.second_delay / TICKS_PER_MS);
        ms3   = MS_W'(w.third_delay / TICKS_PER_MS);

        // Phases two and three swapped: 7..8 ms against 4..5 ms either way round.
        if ((ms2 >= MS_LATE_LO && ms2 <= MS_LATE_HI &&
             ms3 >= MS_EARLY_LO && ms3 <= MS_EARLY_HI) ||
            (ms2 >= MS_EARLY_LO && ms2 <= MS_EARLY_HI &&
             ms3 >= MS_LATE_LO && ms3 <= MS_LATE_HI)) begin
            good1 = 1'b0;
            good2 = 1'b1;
            good3 = 1'b1;
        end
        // Same whole millisecond overrides the swap verdict.
        if (ms2 == ms3) begin
            good2 = 1'b0;
            good3 = 1'b0;
        end

        // Power loss: third zero-period window in a row drops power and phase one.
        if (w.period == '0) begin
            if (loss_cnt >= LOSS_LIMIT) begin
                power_q  = 1'b0;
                first_q  = 1'b0;
                loss_cnt = '0;
            end
            loss_cnt = loss_cnt + 1'b1;
        end else begin
            power_q  = 1'b1;
            first_q  = 1'b1;
            loss_cnt = '0;
        end

        debounce_phase(good1, first_q, first_bad_cnt);
        debounce_phase(good2, second_q, second_bad_cnt);
        debounce_phase(good3, third_q, third_bad_cnt);

        if (fault_en_cfg) begin
            if (good1 && good2 && good3) begin
                clear_cnt = clear_cnt + 1'b1;
                fault_cnt = '0;
                if (clear_cnt >= DEBOUNCE_LIMIT) begin
                    clear_cnt = '0;
                    fault_q   = 1'b0;
                end
            end else begin
                clear_cnt = '0;
                fault_cnt = fault_cnt + 1'b1;
                if (fault_cnt >= DEBOUNCE_LIMIT) begin
                    fault_cnt = '0;
                    fault_q   = 1'b1;
                end
            end
        end else begin
            fault_q = 1'b0;
        end

        f.power_present  = power_q;
        f.first_present  = first_q;
        f.second_present = second_q;
        f.third_present  = third_q;
        f.angle_fault    = fault_q;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic window_t win(input int p, input int d2, input int d3);
        window_t w;
        w.period       = IN_W'(p);
        w.second_delay = IN_W'(d2);
        w.third_delay  = IN_W'(d3);
        return w;
    endfunction

    // Delay for a given lag, jittered inside the tolerance, clamped to the field.
    function automatic int lag_ticks(input int p, input logic [ANGLE_W-1:0] ang);
        longint t, jitter, lag;
        t      = tol_cfg;
        jitter = 0;
        if (t > 1) begin
            jitter = $urandom_range(0, 2 * t - 2);
            jitter = jitter - (t - 1);
        end
        lag = (longint'(p) * (longint'(ang) + jitter)) / ANGLE_SCALE;
        if (lag < 0) lag = 0;
        if (lag > IN_MAX) lag = IN_MAX;
        return int'(lag);
    endfunction

    function automatic int ms_ticks(input int lo_ms, input int hi_ms);
        int d;
        d = $urandom_range(lo_ms * TICKS_PER_MS, (hi_ms + 1) * TICKS_PER_MS - 1);
        return (d > IN_MAX) ? IN_MAX : d;
    endfunction

    function automatic window_t make_window(input window_kind_t kind);
        int p, d2, d3, ms;
        p  = $urandom_range(4000, 60000);
        if ($urandom_range(0, 1)) begin
            d2 = lag_ticks(p, first_angle_cfg);
            d3 = lag_ticks(p, second_angle_cfg);
        end else begin
            d2 = lag_ticks(p, second_angle_cfg);
            d3 = lag_ticks(p, first_angle_cfg);
        end
        case (kind)
            WIN_SECOND_BAD: d2 = $urandom_range(0, IN_MAX);
            WIN_THIRD_BAD:  d3 = $urandom_range(0, IN_MAX);
            WIN_SWAPPED: begin
                p  = $urandom_range(1, IN_MAX);
                d2 = ms_ticks(MS_LATE_LO, MS_LATE_HI);
                d3 = ms_ticks(MS_EARLY_LO, MS_EARLY_HI);
                if ($urandom_range(0, 1)) begin
                    ms = d2;
                    d2 = d3;
                    d3 = ms;
                end
            end
            WIN_SAME_MS: begin
                p  = $urandom_range(0, IN_MAX);
                ms = $urandom_range(0, IN_MAX / TICKS_PER_MS);
                d2 = ms_ticks(ms, ms);
                d3 = ms_ticks(ms, ms);
            end
            WIN_NO_EDGE: begin
                p  = 0;
                d2 = $urandom_range(0, IN_MAX);
                d3 = $urandom_range(0, IN_MAX);
            end
            WIN_NOISE: begin
                p  = $urandom_range(0, IN_MAX);
                d2 = $urandom_range(0, IN_MAX);
                d3 = $urandom_range(0, IN_MAX);
            end
            default: ;
        endcase
        return win(p, d2, d3);
    endfunction

    // Offer one window beat; predict its flags once it is taken.
    // valid is only dropped for a drawn gap, so back-to-back beats keep it high.
    task automatic send_window(input window_t w);
        int     gap;
        flags_t want;
        gap = src_idle_en ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(w);
        do @(posedge aclk); while (!s_tready);
        predict_window(w, want);
        pending_flags.push_back(want);
        windows_sent++;
    endtask

    task automatic send_run(input window_kind_t kind, input int len);
        repeat (len) send_window(make_window(kind));
    endtask

    // Runs of one kind up to 40 long, so every debounce counter can hit its limit.
    task automatic send_mixed(input int count);
        int           pick, len;
        window_kind_t kind;
        while (count > 0) begin
            pick = $urandom_range(0, 99);
            if      (pick < 35) kind = WIN_GOOD;
            else if (pick < 48) kind = WIN_SECOND_BAD;
            else if (pick < 61) kind = WIN_THIRD_BAD;
            else if (pick < 71) kind = WIN_SWAPPED;
            else if (pick < 79) kind = WIN_SAME_MS;
            else if (pick < 87) kind = WIN_NO_EDGE;
            else                kind = WIN_NOISE;
            len = $urandom_range(1, 40);
            if (len > count) len = count;
            send_run(kind, len);
            count -= len;
        end
    endtask

    // Stop offering, wait for every expected beat, then let the pipeline empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_flags.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Setup cycle, access cycle, done once pready is seen high.
    task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FAULT_ENABLE: fault_en_cfg     = value[0];
            REG_FIRST_ANGLE:  first_angle_cfg  = value[ANGLE_W-1:0];
            REG_SECOND_ANGLE: second_angle_cfg = value[ANGLE_W-1:0];
            REG_TOLERANCE:    tol_cfg          = value[TOL_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic configure_monitor(input logic fault_en, input int ang1,
                                     input int ang2, input int tol);
        write_reg(REG_FAULT_ENABLE, APB_DW'(fault_en));
        write_reg(REG_FIRST_ANGLE, APB_DW'(ang1));
        write_reg(REG_SECOND_ANGLE, APB_DW'(ang2));
        write_reg(REG_TOLERANCE, APB_DW'(tol));
    endtask

    // ------------------------------------------------------------------
    // Result checking: every m-side beat against the oldest expectation.
    // ------------------------------------------------------------------
    task automatic check_flags(input flags_t got);
        flags_t want;
        results_seen++;
        if (pending_flags.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: result beat %b with nothing expected", $time, got);
        end else begin
            want = pending_flags.pop_front();
            if (want.angle_fault) fault_results++;
            if (got.power_present  !== want.power_present  ||
                got.first_present  !== want.first_present  ||
                got.second_present !== want.second_present ||
                got.third_present  !== want.third_present  ||
                got.angle_fault    !== want.angle_fault) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"%0t: result %0d power/first/second/third/fault ",
                              "expected %b%b%b%b%b got %b%b%b%b%b"},
                             $time, results_seen,
                             want.power_present, want.first_present,
                             want.second_present, want.third_present, want.angle_fault,
                             got.power_present, got.first_present,
                             got.second_present, got.third_present, got.angle_fault);
            end
        end
    endtask

    // Receiver: random stall after each beat, plus the long hold-off.
    initial begin : result_sink
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                check_flags(flags_t'(m_tdata[$bits(flags_t)-1:0]));
                stall = sink_idle_en ? $urandom_range(0, 5) : 0;
            end else if (stall > 0) begin
                stall--;
            end
            m_tready <= aresetn && hold_left == 0 && stall == 0;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset register values; field extremes and each rule hit on purpose.
    task automatic test_directed_windows();
        int p20, lag120, lag240;
        p20    = 20 * TICKS_PER_MS;                 // 50 Hz period
        lag120 = p20 * 120 / ANGLE_SCALE + 1;
        lag240 = p20 * 240 / ANGLE_SCALE + 1;
        send_window(win(p20, lag120, lag240));      // healthy mains
        send_window(win(IN_MAX, IN_MAX, IN_MAX));   // all-ones, same whole ms
        send_window(win(0, 0, 0));                  // three zero periods: power drops
        send_window(win(0, 0, 0));
        send_window(win(0, 0, 0));
        send_window(win(0, IN_MAX, 0));             // fourth zero period, counts toward the next drop
        send_window(win(p20, lag240, lag120));      // power back, delays swapped in angle
        // swap rule, both orders and the ms band edges
        send_window(win(p20, 7 * TICKS_PER_MS, 4 * TICKS_PER_MS));
        send_window(win(p20, 5 * TICKS_PER_MS, 8 * TICKS_PER_MS));
        send_window(win(p20, 9 * TICKS_PER_MS - 1, 6 * TICKS_PER_MS - 1));
        send_window(win(p20, 4 * TICKS_PER_MS - 1, 7 * TICKS_PER_MS));
        // same whole millisecond, including one inside the late swap band
        send_window(win(p20, TICKS_PER_MS, 2 * TICKS_PER_MS - 1));
        send_window(win(p20, 7 * TICKS_PER_MS, 8 * TICKS_PER_MS - 1));
        // strict window edges at 110 and 130 degrees (p=18000 gives exact ticks)
        send_window(win(18000, 11000, 13000));
        send_window(win(18000, 11001, 12999));
        send_window(win(18000, 21001, 22999));
        send_window(win(1, 0, 0));
        send_window(win(IN_MAX, 0, IN_MAX));
        send_window(win(IN_MAX, 87381, 87381 * 2 > IN_MAX ? IN_MAX : 87381 * 2));
    endtask

    // Fault detection on, long runs of each kind drive all debounce counters.
    task automatic test_flag_debounce();
        settle();
        configure_monitor(1'b1, FIRST_ANGLE_RST, SECOND_ANGLE_RST, TOLERANCE_RST);
        send_mixed(600);
    endtask

    // Raise the fault, disable detection (forced clear), then re-enable, raise it again and clear it.
    task automatic test_fault_disable();
        settle();
        send_run(WIN_SECOND_BAD, 36);
        settle();
        write_reg(REG_FAULT_ENABLE, APB_DW'(1'b0));
        send_run(WIN_SECOND_BAD, 8);
        send_run(WIN_GOOD, 4);
        settle();
        write_reg(REG_FAULT_ENABLE, APB_DW'(1'b1));
        send_run(WIN_THIRD_BAD, 34);
        send_run(WIN_GOOD, 34);
    endtask

    // Angles and tolerance at their range ends and at full register width.
    task automatic test_register_extremes();
        settle();
        configure_monitor(1'b1, 0, 360, 180);       // A-T negative, widest windows
        send_mixed(150);
        settle();
        configure_monitor(1'b1, (1 << ANGLE_W) - 1, 0, 0);  // zero tolerance: nothing fits
        send_mixed(150);
        settle();
        configure_monitor(1'b1, 360, 120, (1 << TOL_W) - 1);
        send_mixed(150);
        settle();
        configure_monitor(1'b1, FIRST_ANGLE_RST, SECOND_ANGLE_RST, TOLERANCE_RST);
    endtask

    // Receiver holds off while the sender streams with no gaps: pipeline fills, s_tready drops.
    task automatic test_backpressure();
        settle();
        src_idle_en = 1'b0;
        hold_left <= HOLD_CYCLES;
        send_mixed(80);
        src_idle_en = 1'b1;
    endtask

    // Sender pauses until every expected beat is back, between short bursts.
    task automatic test_sender_pause();
        repeat (5) begin
            send_mixed(30);
            settle();
        end
    endtask

    // Full rate on both sides.
    task automatic test_full_rate();
        settle();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        send_mixed(300);
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    // Mixed traffic with fault detection toggled part way.
    task automatic test_mixed_traffic();
        send_mixed(250);
        settle();
        write_reg(REG_FAULT_ENABLE, APB_DW'(1'b0));
        send_mixed(150);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_windows();
        test_flag_debounce();
        test_fault_disable();
        test_register_extremes();
        test_backpressure();
        test_sender_pause();
        test_full_rate();
        test_mixed_traffic();
        settle();

        $display("summary: %0d windows sent, %0d result beats checked, %0d register writes",
                 windows_sent, results_seen, reg_writes);
        $display("summary: %0d results with angle fault set, %0d mismatches",
                 fault_results, mismatches);
        if (mismatches == 0 && pending_flags.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
